FILE: sv/rss_pkg.sv
// -----------------------------------------------------------------------------
// Radar sweep scheduler package
// Shared widths, reset values, codes and the lane control bundle.
// -----------------------------------------------------------------------------
package rss_pkg;

    localparam int TABLE_DEPTH = 8;
    localparam int TBL_IDX_W   = 3;
    localparam int MAX_SENSORS = 4;
    localparam int RANGE_W     = 16;
    localparam int TIME_W      = 32;
    localparam int DELAY_W     = 16;
    localparam int ANGLE_W     = 8;
    localparam int COUNT_W     = 4;
    localparam int CLOSEST_W   = 10;
    localparam int CFG_IDX_W   = 2;

    localparam int IN_TDATA_W  = 120;
    localparam int OUT_TDATA_W = 24;

    localparam logic [CLOSEST_W-1:0] NO_RANGE = 10'd999;

    localparam logic [DELAY_W-1:0] RST_READ_DELAY  = 16'd50;
    localparam logic [DELAY_W-1:0] RST_START_DELAY = 16'd20;

    localparam int NUM_SENSORS_DEF   = 4;
    localparam int NUM_POSITIONS_DEF = 2;
    localparam int POS_MIN_DEG_DEF   = 65;
    localparam int POS_STEP_DEG_DEF  = 45;

    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_LIMIT = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_READ_DELAY  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_DELAY = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SERVO_EN    = 2'd2;

    typedef struct packed {
        logic range_we;
        logic limit_we;
    } t_lane_ctrl;

endpackage

FILE: sv/rss_lane.sv
// -----------------------------------------------------------------------------
// Radar sweep scheduler table lane
// Holds one range entry and its limit, and flags an intrusion and the clipped
// range for the merge tree.
// -----------------------------------------------------------------------------
module rss_lane (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  rss_pkg::t_lane_ctrl               i_ctrl,
    input  logic [rss_pkg::RANGE_W-1:0]       i_range_data,
    input  logic [rss_pkg::RANGE_W-1:0]       i_limit_data,
    output logic                              o_hit,
    output logic [rss_pkg::CLOSEST_W-1:0]     o_clip
);
    import rss_pkg::*;

    logic [RANGE_W-1:0]   r_range;
    logic [RANGE_W-1:0]   r_limit;
    logic                 r_hit;
    logic [CLOSEST_W-1:0] r_clip;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range <= '0;
            r_limit <= '0;
            r_hit   <= 1'b0;
            r_clip  <= NO_RANGE;
        end else begin
            if (i_ctrl.range_we) begin
                r_range <= i_range_data;
            end
            if (i_ctrl.limit_we) begin
                r_limit <= i_limit_data;
            end
            r_hit  <= (r_range != '0) && (r_range < r_limit);
            r_clip <= (r_range < RANGE_W'(NO_RANGE)) ? r_range[CLOSEST_W-1:0] : NO_RANGE;
        end
    end

    assign o_hit  = r_hit;
    assign o_clip = r_clip;

endmodule

FILE: sv/rss_merge.sv
// -----------------------------------------------------------------------------
// Radar sweep scheduler merge tree
// Three registered levels that add the lane hits and take the smallest range.
// -----------------------------------------------------------------------------
module rss_merge (
    input  logic                          i_clk,
    input  logic [rss_pkg::TABLE_DEPTH-1:0] i_hit,
    input  logic [rss_pkg::CLOSEST_W-1:0] i_clip [rss_pkg::TABLE_DEPTH],
    output logic [rss_pkg::COUNT_W-1:0]   o_count,
    output logic [rss_pkg::CLOSEST_W-1:0] o_closest
);
    import rss_pkg::*;

    localparam int L1_N = TABLE_DEPTH / 2;
    localparam int L2_N = TABLE_DEPTH / 4;

    function automatic logic [CLOSEST_W-1:0] f_min(input logic [CLOSEST_W-1:0] a,
                                                   input logic [CLOSEST_W-1:0] b);
        return (a < b) ? a : b;
    endfunction

    logic [1:0]           r_cnt1 [L1_N];
    logic [CLOSEST_W-1:0] r_min1 [L1_N];
    logic [2:0]           r_cnt2 [L2_N];
    logic [CLOSEST_W-1:0] r_min2 [L2_N];
    logic [COUNT_W-1:0]   r_cnt3;
    logic [CLOSEST_W-1:0] r_min3;

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < L1_N; k++) begin
            r_cnt1[k] <= {1'b0, i_hit[2*k]} + {1'b0, i_hit[2*k+1]};
            r_min1[k] <= f_min(i_clip[2*k], i_clip[2*k+1]);
        end
        for (int k = 0; k < L2_N; k++) begin
            r_cnt2[k] <= {1'b0, r_cnt1[2*k]} + {1'b0, r_cnt1[2*k+1]};
            r_min2[k] <= f_min(r_min1[2*k], r_min1[2*k+1]);
        end
        r_cnt3 <= {1'b0, r_cnt2[0]} + {1'b0, r_cnt2[1]};
        r_min3 <= f_min(r_min2[0], r_min2[1]);
    end

    assign o_count   = r_cnt3;
    assign o_closest = r_min3;

endmodule

FILE: sv/radar_sweep_scheduler.sv
// -----------------------------------------------------------------------------
// Radar sweep scheduler
// Times the start and capture phases of a sweeping range radar, stores the
// ranges in eight table lanes and reports intrusions and the closest range.
//
// Channel   Direction  Handshake                     Carries
// s_axis    in         s_axis_tvalid/s_axis_tready   tick or limit write
// m_axis    out        m_axis_tvalid/m_axis_tready   one result per transaction
// cfg       in         i_cfg_valid/o_cfg_ready       register index and data
//
// Each item passes the elapsed-time stage, the table update and the lane and
// merge registers before its result is registered; the next item is taken
// only after that result has been loaded into the output register.
// The input side accepts again while a result waits at the output.
// A stalled output holds the item in the wait state until the result register
// frees. Reset is synchronous and clears the table lanes at once.
// -----------------------------------------------------------------------------
module radar_sweep_scheduler #(
    parameter int NUM_SENSORS   = rss_pkg::NUM_SENSORS_DEF,
    parameter int NUM_POSITIONS = rss_pkg::NUM_POSITIONS_DEF,
    parameter int POS_MIN_DEG   = rss_pkg::POS_MIN_DEG_DEF,
    parameter int POS_STEP_DEG  = rss_pkg::POS_STEP_DEG_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // now_ms, range_0, range_1, range_2, range_3, limit_index, limit_value
    input  logic [rss_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // operation
    input  logic                              s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // start_ranges, captured, servo_angle, intrusion_count, closest_range
    output logic [rss_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [rss_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [rss_pkg::DELAY_W-1:0]       i_cfg_data
);
    import rss_pkg::*;

    localparam int POS_IDX_W = (NUM_POSITIONS > 1) ? $clog2(NUM_POSITIONS) : 1;
    localparam logic [POS_IDX_W-1:0] LAST_POS = POS_IDX_W'(NUM_POSITIONS - 1);
    localparam int SLOT_RAW = $clog2(NUM_SENSORS * NUM_POSITIONS + 1);
    localparam int SLOT_W = (SLOT_RAW > TBL_IDX_W) ? SLOT_RAW : TBL_IDX_W + 1;
    localparam int ANG_RAW = $clog2(POS_MIN_DEG + (NUM_POSITIONS - 1) * POS_STEP_DEG + 1);
    localparam int ANG_SUM_W = (ANG_RAW > ANGLE_W) ? ANG_RAW : ANGLE_W;
    localparam logic [2:0] MERGE_WAIT = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE    = 4'b0001,
        S_ELAPSED = 4'b0010,
        S_APPLY   = 4'b0100,
        S_WAIT    = 4'b1000
    } t_state;

    t_state r_state, n_state;

    logic [DELAY_W-1:0]   r_read_delay;
    logic [DELAY_W-1:0]   r_start_delay;
    logic                 r_servo_en;

    logic                 r_op;
    logic [TIME_W-1:0]    r_now;
    logic [RANGE_W-1:0]   r_range [MAX_SENSORS];
    logic [TBL_IDX_W-1:0] r_lim_idx;
    logic [RANGE_W-1:0]   r_lim_val;

    logic [TIME_W-1:0]    r_pst, n_pst;
    logic                 r_waiting, n_waiting;
    logic [POS_IDX_W-1:0] r_pos, n_pos;
    logic                 r_rising, n_rising;
    logic [TIME_W-1:0]    r_elapsed;
    logic [DELAY_W-1:0]   r_period;
    logic                 r_start_flag, n_start_flag;
    logic                 r_cap_flag, n_cap_flag;
    logic [2:0]           r_wait_cnt;
    logic                 r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;

    logic                 due;
    logic                 late;
    logic [DELAY_W:0]     late_thr;
    logic                 capture;
    logic                 load_out;
    logic [ANG_SUM_W-1:0] angle_sum;

    t_lane_ctrl           lane_ctrl [TABLE_DEPTH];
    logic [RANGE_W-1:0]   lane_range [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] lane_hit;
    logic [CLOSEST_W-1:0] lane_clip [TABLE_DEPTH];
    logic [COUNT_W-1:0]   merge_count;
    logic [CLOSEST_W-1:0] merge_closest;

    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_read_delay  <= RST_READ_DELAY;
            r_start_delay <= RST_START_DELAY;
            r_servo_en    <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_READ_DELAY:  r_read_delay  <= i_cfg_data;
                CFG_START_DELAY: r_start_delay <= i_cfg_data;
                CFG_SERVO_EN:    r_servo_en    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_op      <= s_axis_tuser;
            r_now     <= s_axis_tdata[31:0];
            r_range[0] <= s_axis_tdata[47:32];
            r_range[1] <= s_axis_tdata[63:48];
            r_range[2] <= s_axis_tdata[79:64];
            r_range[3] <= s_axis_tdata[95:80];
            r_lim_idx <= s_axis_tdata[98:96];
            r_lim_val <= s_axis_tdata[114:99];
        end
        if (r_state == S_ELAPSED) begin
            r_elapsed <= r_now - r_pst;
            r_period  <= r_waiting ? r_read_delay : r_start_delay;
        end
    end

    always_comb begin
        late_thr = {1'b0, r_period} + {2'b0, r_period[DELAY_W-1:1]};
        due      = (r_elapsed >= TIME_W'(r_period));
        late     = (r_elapsed >= TIME_W'(late_thr));
        capture  = (r_op == OP_TICK) && due && r_waiting;

        n_pst        = r_pst;
        n_waiting    = r_waiting;
        n_pos        = r_pos;
        n_rising     = r_rising;
        n_start_flag = 1'b0;
        n_cap_flag   = 1'b0;
        if ((r_op == OP_TICK) && due) begin
            n_pst = late ? r_now : (r_pst + TIME_W'(r_period));
            if (r_waiting) begin
                n_waiting  = 1'b0;
                n_cap_flag = 1'b1;
                if (r_servo_en) begin
                    if (r_rising && (r_pos < LAST_POS)) begin
                        n_pos = r_pos + 1'b1;
                        if (n_pos == LAST_POS) begin
                            n_rising = 1'b0;
                        end
                    end else if (!r_rising && (r_pos != '0)) begin
                        n_pos = r_pos - 1'b1;
                        if (n_pos == '0) begin
                            n_rising = 1'b1;
                        end
                    end
                end
            end else begin
                n_waiting    = 1'b1;
                n_start_flag = 1'b1;
            end
        end
    end

    always_comb begin
        for (int e = 0; e < TABLE_DEPTH; e++) begin
            lane_ctrl[e].range_we = 1'b0;
            lane_ctrl[e].limit_we = (r_state == S_APPLY) && (r_op == OP_LIMIT) &&
                                    (r_lim_idx == TBL_IDX_W'(e));
            lane_range[e] = r_range[0];
            for (int s = 0; s < NUM_SENSORS; s++) begin
                if ((SLOT_W'(r_pos) + SLOT_W'((NUM_SENSORS - 1 - s) * NUM_POSITIONS))
                        == SLOT_W'(e)) begin
                    lane_ctrl[e].range_we = (r_state == S_APPLY) && capture;
                    lane_range[e] = r_range[s];
                end
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = S_ELAPSED;
                end
            end
            S_ELAPSED: n_state = S_APPLY;
            S_APPLY:   n_state = S_WAIT;
            S_WAIT: begin
                if (load_out) begin
                    n_state = S_IDLE;
                end
            end
            default:   n_state = S_IDLE;
        endcase
    end

    assign load_out  = (r_state == S_WAIT) && (r_wait_cnt == MERGE_WAIT) &&
                       (!r_out_valid || m_axis_tready);
    assign angle_sum = ANG_SUM_W'(POS_MIN_DEG) +
                       ANG_SUM_W'(r_pos) * ANG_SUM_W'(POS_STEP_DEG);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_pst        <= '0;
            r_waiting    <= 1'b0;
            r_pos        <= '0;
            r_rising     <= 1'b1;
            r_start_flag <= 1'b0;
            r_cap_flag   <= 1'b0;
            r_wait_cnt   <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_APPLY) begin
                r_pst        <= n_pst;
                r_waiting    <= n_waiting;
                r_pos        <= n_pos;
                r_rising     <= n_rising;
                r_start_flag <= n_start_flag;
                r_cap_flag   <= n_cap_flag;
                r_wait_cnt   <= '0;
            end else if ((r_state == S_WAIT) && (r_wait_cnt != MERGE_WAIT)) begin
                r_wait_cnt <= r_wait_cnt + 3'd1;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_data <= {merge_closest, merge_count, angle_sum[ANGLE_W-1:0],
                           r_cap_flag, r_start_flag};
        end
    end

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_lane
        rss_lane u_lane (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (lane_ctrl[g]),
            .i_range_data (lane_range[g]),
            .i_limit_data (r_lim_val),
            .o_hit        (lane_hit[g]),
            .o_clip       (lane_clip[g])
        );
    end

    rss_merge u_merge (
        .i_clk     (i_clk),
        .i_hit     (lane_hit),
        .i_clip    (lane_clip),
        .o_count   (merge_count),
        .o_closest (merge_closest)
    );

endmodule

FILE: sv/rss_checker.sv
// -----------------------------------------------------------------------------
// Radar sweep scheduler port checker
// Watches the top level ports over time and is bound to every instance.
// -----------------------------------------------------------------------------
module rss_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              s_axis_tvalid,
    input logic                              s_axis_tready,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [rss_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);
    import rss_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("Result transaction changed while stalled.");

    a_one_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("Input accepted a second transaction while busy.");

    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[1]))
        else $error("Start and capture reported in one result.");

    a_closest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[23:14] <= NO_RANGE))
        else $error("Closest range above the no-range value.");

    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[13:10] <= COUNT_W'(TABLE_DEPTH)))
        else $error("Intrusion count above the table depth.");

endmodule

bind radar_sweep_scheduler rss_checker u_rss_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

FILE: tb/radar_sweep_scheduler_test.sv
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// Radar sweep scheduler testbench
// Drives tick and limit-write transactions with random gaps, writes the timing
// and servo registers between phases, and checks every result against a
// scoreboard that mirrors the phase timing, sweep and range tables.
// -----------------------------------------------------------------------------
module radar_sweep_scheduler_test;
    import rss_pkg::*;

    localparam int NUM_SENSORS    = NUM_SENSORS_DEF;
    localparam int NUM_POSITIONS  = NUM_POSITIONS_DEF;
    localparam int POS_MIN_DEG    = POS_MIN_DEG_DEF;
    localparam int POS_STEP_DEG   = POS_STEP_DEG_DEF;
    localparam int PHASE_COUNT    = 12;
    localparam int PHASE_ITEMS    = 100;
    localparam int SETTLE_CYCLES  = 12;
    localparam int PRESSURE_AT    = 300;
    localparam int PRESSURE_LEN   = 500;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int REPORT_LIMIT   = 10;

    typedef struct packed {
        logic [CLOSEST_W-1:0] closest;
        logic [COUNT_W-1:0]   intrusions;
        logic [ANGLE_W-1:0]   angle;
        logic                 captured;
        logic                 start_cmd;
    } t_sweep_report;

    class sweep_scoreboard;
        t_sweep_report     expected_reports[$];
        int unsigned       failures;
        bit [RANGE_W-1:0]  range_mem[TABLE_DEPTH];
        bit [RANGE_W-1:0]  limit_mem[TABLE_DEPTH];
        bit [TIME_W-1:0]   phase_mark;
        bit                awaiting_capture;
        int unsigned       sweep_pos;
        bit                sweep_up;
        bit [DELAY_W-1:0]  read_delay;
        bit [DELAY_W-1:0]  start_delay;
        bit                servo_on;

        function new();
            foreach (range_mem[i]) begin
                range_mem[i] = '0;
                limit_mem[i] = '0;
            end
            phase_mark       = '0;
            awaiting_capture = 1'b0;
            sweep_pos        = 0;
            sweep_up         = 1'b1;
            read_delay       = RST_READ_DELAY;
            start_delay      = RST_START_DELAY;
            servo_on         = 1'b0;
            failures         = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [DELAY_W-1:0] value);
            case (idx)
                CFG_READ_DELAY:  read_delay  = value;
                CFG_START_DELAY: start_delay = value;
                CFG_SERVO_EN:    servo_on    = value[0];
                default: ;
            endcase
        endfunction

        function bit phase_elapsed(bit [TIME_W-1:0] now, bit [DELAY_W-1:0] period);
            bit [TIME_W-1:0] spent;
            spent = now - phase_mark;
            if (spent < TIME_W'(period))
                return 1'b0;
            if (spent >= TIME_W'(period) + TIME_W'(period >> 1))
                phase_mark = now - TIME_W'(period);
            phase_mark = phase_mark + TIME_W'(period);
            return 1'b1;
        endfunction

        function void note_item(logic op, logic [IN_TDATA_W-1:0] d);
            t_sweep_report    rep;
            bit [TIME_W-1:0]  now;
            int unsigned      slot;
            bit [CLOSEST_W-1:0] nearest;
            bit [COUNT_W-1:0] hits;
            rep = '0;
            if (op == OP_LIMIT) begin
                limit_mem[d[98:96]] = d[114:99];
            end else begin
                now = d[31:0];
                if (awaiting_capture) begin
                    if (phase_elapsed(now, read_delay)) begin
                        for (int s = 0; s < NUM_SENSORS; s++) begin
                            slot = sweep_pos + (NUM_SENSORS - 1 - s) * NUM_POSITIONS;
                            if (slot < TABLE_DEPTH)
                                range_mem[slot] = d[32 + RANGE_W * s +: RANGE_W];
                        end
                        if (servo_on) begin
                            if (sweep_up && sweep_pos < NUM_POSITIONS - 1) begin
                                sweep_pos++;
                                if (sweep_pos == NUM_POSITIONS - 1)
                                    sweep_up = 1'b0;
                            end else if (!sweep_up && sweep_pos > 0) begin
                                sweep_pos--;
                                if (sweep_pos == 0)
                                    sweep_up = 1'b1;
                            end
                        end
                        awaiting_capture = 1'b0;
                        rep.captured = 1'b1;
                    end
                end else if (phase_elapsed(now, start_delay)) begin
                    awaiting_capture = 1'b1;
                    rep.start_cmd = 1'b1;
                end
            end
            nearest = NO_RANGE;
            hits    = '0;
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                if (range_mem[i] != 0 && range_mem[i] < limit_mem[i])
                    hits++;
                if (range_mem[i] < RANGE_W'(nearest))
                    nearest = range_mem[i][CLOSEST_W-1:0];
            end
            rep.intrusions = hits;
            rep.closest    = nearest;
            rep.angle      = ANGLE_W'(POS_MIN_DEG + sweep_pos * POS_STEP_DEG);
            expected_reports.push_back(rep);
        endfunction

        function void check_result(logic [OUT_TDATA_W-1:0] d);
            t_sweep_report got;
            t_sweep_report want;
            got = d;
            if (expected_reports.size() == 0) begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display("unexpected result transaction: %h", d);
                return;
            end
            want = expected_reports.pop_front();
            if (got.start_cmd !== want.start_cmd || got.captured !== want.captured ||
                got.angle !== want.angle || got.intrusions !== want.intrusions ||
                got.closest !== want.closest) begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display({$sformatf("mismatch: start %b/%b captured %b/%b angle %0d/%0d ",
                                        want.start_cmd, got.start_cmd, want.captured,
                                        got.captured, want.angle, got.angle),
                              $sformatf("count %0d/%0d closest %0d/%0d (expected/actual)",
                                        want.intrusions, got.intrusions,
                                        want.closest, got.closest)});
            end
        endfunction
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   s_axis_tuser = OP_TICK;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index = CFG_READ_DELAY;
    logic [DELAY_W-1:0]     i_cfg_data = '0;

    sweep_scoreboard  sb = new();
    bit               steady_flow = 1'b0;
    bit [TIME_W-1:0]  clock_ms = '0;
    int unsigned      results_seen = 0;
    bit [DELAY_W-1:0] phase_read[7]  = '{16'd5, 16'd1, 16'd0, 16'hFFFF, 16'hFFFF, 16'd2, 16'd0};
    bit [DELAY_W-1:0] phase_start[7] = '{16'd3, 16'd1, 16'd0, 16'hFFFF, 16'd1, 16'd40, 16'd7};
    bit               phase_servo[7] = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};

    radar_sweep_scheduler u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic int unsigned idle_len();
        int unsigned roll;
        if (steady_flow)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic bit [RANGE_W-1:0] pick_range();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return RANGE_W'($urandom_range(997, 1000));
            3, 4, 5: return RANGE_W'($urandom_range(1, 1200));
            6, 7:    return RANGE_W'($urandom_range(0, 3000));
            default: return RANGE_W'($urandom);
        endcase
    endfunction

    function automatic bit [RANGE_W-1:0] pick_limit();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2, 3:    return RANGE_W'($urandom_range(1, 1200));
            default: return RANGE_W'($urandom);
        endcase
    endfunction

    function automatic logic [IN_TDATA_W-1:0] pack_item(
        bit [TIME_W-1:0] now, bit [RANGE_W-1:0] r0, bit [RANGE_W-1:0] r1,
        bit [RANGE_W-1:0] r2, bit [RANGE_W-1:0] r3, bit [2:0] li, bit [RANGE_W-1:0] lv);
        return {5'b0, lv, li, r3, r2, r1, r0, now};
    endfunction

    task automatic send_item(logic op, logic [IN_TDATA_W-1:0] d);
        int unsigned gap;
        gap = idle_len();
        @(negedge i_clk);
        if (gap != 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tdata  = d;
        s_axis_tuser  = op;
        s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_item(op, d);
    endtask

    task automatic send_tick(bit [TIME_W-1:0] now, bit [RANGE_W-1:0] r0, bit [RANGE_W-1:0] r1,
                             bit [RANGE_W-1:0] r2, bit [RANGE_W-1:0] r3);
        send_item(OP_TICK, pack_item(now, r0, r1, r2, r3, 3'($urandom), 16'($urandom)));
    endtask

    task automatic send_limit(bit [2:0] li, bit [RANGE_W-1:0] lv);
        send_item(OP_LIMIT, pack_item($urandom, RANGE_W'($urandom), RANGE_W'($urandom),
                                      RANGE_W'($urandom), RANGE_W'($urandom), li, lv));
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [DELAY_W-1:0] value);
        @(negedge i_clk);
        i_cfg_index = idx;
        i_cfg_data  = value;
        i_cfg_valid = 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_register(idx, value);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (sb.expected_reports.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_phase(bit [DELAY_W-1:0] rd, bit [DELAY_W-1:0] sd, bit servo);
        int unsigned longest;
        bit [TIME_W-1:0] step;
        drain_results();
        write_register(CFG_READ_DELAY, rd);
        write_register(CFG_START_DELAY, sd);
        write_register(CFG_SERVO_EN, DELAY_W'(servo));
        longest = 32'((rd > sd) ? rd : sd);
        repeat (PHASE_ITEMS) begin
            if ($urandom_range(0, 99) < 15) begin
                send_limit(3'($urandom), pick_limit());
            end else begin
                case ($urandom_range(0, 9))
                    0:          step = 0;
                    1:          step = 1;
                    2, 3, 4, 5: step = $urandom_range(0, longest + 1);
                    6, 7:       step = $urandom_range(longest, 2 * longest + 2);
                    8:          step = $urandom;
                    default:    step = $urandom_range(0, 3);
                endcase
                clock_ms = clock_ms + step;
                send_tick(clock_ms, pick_range(), pick_range(), pick_range(), pick_range());
            end
        end
    endtask

    initial begin
        forever begin
            @(negedge i_clk);
            m_axis_tready = 1'b1;
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready) begin
                sb.check_result(m_axis_tdata);
                results_seen++;
                if (results_seen == PRESSURE_AT) begin
                    for (int n = 0; n < PRESSURE_LEN; n++) begin
                        @(negedge i_clk);
                        m_axis_tready = 1'b0;
                    end
                end else begin
                    repeat (idle_len()) begin
                        @(negedge i_clk);
                        m_axis_tready = 1'b0;
                    end
                end
            end else if ($urandom_range(0, 9) == 0) begin
                repeat (idle_len()) begin
                    @(negedge i_clk);
                    m_axis_tready = 1'b0;
                end
            end
        end
    end

    initial begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (i_cfg_valid && o_cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("radar_sweep_scheduler_test: errors");
        $finish;
    end

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Default timing: limits at the extremes, on-time and late phases, time wrap.
        send_limit(3'd0, 16'hFFFF);
        send_limit(3'd7, 16'd0);
        send_limit(3'd3, 16'd1000);
        send_limit(3'd1, 16'd999);
        send_limit(3'd2, 16'd1);
        send_limit(3'd4, 16'd500);
        send_limit(3'd5, 16'hFFFF);
        send_limit(3'd6, 16'd2);
        send_tick(32'd0, 16'd10, 16'd20, 16'd30, 16'd40);
        send_tick(32'd20, 16'd10, 16'd20, 16'd30, 16'd40);
        send_tick(32'd69, 16'd10, 16'd20, 16'd30, 16'd40);
        send_tick(32'd70, 16'd0, 16'hFFFF, 16'd998, 16'd1);
        send_tick(32'd90, 16'd5, 16'd5, 16'd5, 16'd5);
        send_tick(32'd165, 16'd999, 16'd1000, 16'd0, 16'd500);
        send_tick(32'hFFFF_FFFF, 16'd7, 16'd7, 16'd7, 16'd7);
        send_tick(32'd48, 16'd1, 16'd1, 16'd1, 16'd1);
        send_tick(32'd49, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_tick(32'd69, 16'd0, 16'd0, 16'd0, 16'd0);
        send_tick(32'd119, 16'd1, 16'd2, 16'd3, 16'd4);
        send_limit(3'd7, 16'hFFFF);
        clock_ms = 32'd119;

        for (int p = 0; p < PHASE_COUNT; p++) begin
            steady_flow = (p % 3 == 2);
            if (p == 4)
                clock_ms = 32'hFFFF_FF00;
            if (p < 7)
                run_phase(phase_read[p], phase_start[p], phase_servo[p]);
            else
                run_phase(DELAY_W'($urandom_range(1, 60)), DELAY_W'($urandom_range(1, 60)),
                          1'($urandom));
        end

        drain_results();
        repeat (20) @(posedge i_clk);
        if (sb.failures == 0 && sb.expected_reports.size() == 0)
            $display("radar_sweep_scheduler_test: clean");
        else
            $display("radar_sweep_scheduler_test: errors");
        $finish;
    end

endmodule
